>>> hdl/gbn_pkg.sv
// Shared types, constants and helpers for the go-back-n sender core.
// No dependencies; imported by the core and by its port checker.
package gbn_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int MAX_WINDOW_DEF   = 16;

    localparam int IN_TDATA_W  = 256;
    localparam int OUT_TDATA_W = 232;
    localparam int PADDR_W     = 3;

    localparam logic [4:0] WINDOW_SIZE_RST = 5'd8;
    localparam logic       REG_WINDOW_SIZE = 1'b0;

    // Bit positions of the result fields inside m_tdata
    localparam int TCMD_LSB = 224;
    localparam int OVF_BIT  = 226;

    localparam logic [1:0] OP_MSG     = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    localparam logic [1:0] TCMD_NONE  = 2'd0;
    localparam logic [1:0] TCMD_START = 2'd1;
    localparam logic [1:0] TCMD_STOP  = 2'd2;

    localparam int SUM_W = 13;

    typedef struct packed {
        logic        has_packet;
        logic        last;
        logic        overflow;
        logic [1:0]  timer_cmd;
        logic [31:0] word2;
        logic [63:0] word1;
        logic [63:0] word0;
        logic [31:0] check;
        logic [31:0] seq;
    } result_t;

    // Sum of eight bytes, each taken as a signed value
    function automatic logic signed [10:0] byte_sum8(input logic [63:0] w);
        logic signed [10:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            acc = acc + 11'(signed'(w[8*i +: 8]));
        end
        return acc;
    endfunction

endpackage

>>> hdl/go_back_n_sender_core.sv
// Go-back-n ARQ sender core: payload ring memory, window control, result queue.
// Depends on gbn_pkg.
//
// Each input transaction is a message (tuser 0), an ack packet (tuser 1) or a
// timer expiry (tuser 2). Messages are kept in a single-port-read ring memory
// indexed by sequence number; packets leave one per cycle while m_tready is high
// through a two-entry result queue, so the core keeps taking new transactions
// while results wait. A stored message or valid ack passes decode and prepare,
// then sends each packet it releases (at most one window); a timeout resends all
// outstanding packets after decode; other transactions are answered in decode.
// Packets share the one read port of the payload memory and pass the issue stage
// and read register into the result queue. No clearing pass is run after reset.
// window_size lies at byte address 0 of the register port.
module go_back_n_sender_core #(
    parameter int BUFFER_DEPTH = gbn_pkg::BUFFER_DEPTH_DEF,
    parameter int MAX_WINDOW   = gbn_pkg::MAX_WINDOW_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: payload_word0, payload_word1, payload_word2, ack_seq_field,
    //          ack_number, ack_check
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gbn_pkg::IN_TDATA_W-1:0] s_tdata,
    // s_tuser: op
    input  logic [1:0]                     s_tuser,
    // m_tdata: out_seq, out_check, out_word0, out_word1, out_word2, timer_cmd,
    //          overflow
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gbn_pkg::OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: has_packet
    output logic                           m_tuser,
    output logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gbn_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import gbn_pkg::*;

    localparam int IDX_W   = $clog2(BUFFER_DEPTH);
    localparam int WIN_CAP = (MAX_WINDOW < BUFFER_DEPTH) ? MAX_WINDOW : BUFFER_DEPTH;
    localparam int WIN_W   = $clog2(WIN_CAP + 1);
    localparam int MEM_W   = 160 + SUM_W;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUFFER_DEPTH - 1);
    localparam logic [31:0]      DEPTH_32 = 32'(BUFFER_DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_PREP   = 2'd2;
    localparam logic [1:0] ST_SEND   = 2'd3;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : i + 1'b1;
    endfunction

    // Control state
    logic [1:0]       state_reg, state_next;
    logic [4:0]       win_size_reg, win_size_next;
    logic [31:0]      base_reg, base_next;
    logic [31:0]      next_reg, next_next;
    logic [31:0]      stored_reg, stored_next;
    logic [IDX_W-1:0] base_idx_reg, base_idx_next;
    logic [IDX_W-1:0] next_idx_reg, next_idx_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [31:0]      scan_seq_reg, scan_seq_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [WIN_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       tcmd_reg, tcmd_next;
    logic             fresh_reg, fresh_next;
    logic             iss_valid_reg;
    logic [1:0]       fifo_count_reg, fifo_count_next;
    logic             fifo_wr_ptr_reg, fifo_rd_ptr_reg;

    // Latched transaction
    logic [1:0]  op_reg;
    logic [63:0] w0_reg, w1_reg;
    logic [31:0] w2_reg, ack_s_reg, ack_a_reg, ack_c_reg;

    // Issue stage descriptor, lines up with the memory read data
    logic        iss_pkt_reg, iss_ovf_reg, iss_last_reg;
    logic [31:0] iss_seq_reg;
    logic [1:0]  iss_tcmd_reg;

    logic [MEM_W-1:0] mem [BUFFER_DEPTH];
    logic [MEM_W-1:0] rd_data_reg;
    result_t          fifo_reg [2];

    // Window arithmetic
    logic [WIN_W-1:0] eff_w;
    logic [31:0]      in_flight, ack_dist, avail;
    logic             ack_ok, full;
    logic [WIN_W-1:0] room, cnt_fresh;
    logic [IDX_W:0]   ofs, idx_sum;

    // Issue control
    logic             emit_req, emit_pkt, emit_ovf, emit_last, emit;
    logic [31:0]      emit_seq;
    logic [1:0]       emit_tcmd;
    logic             can_issue, pop, mem_we, take;
    logic [2:0]       occ;
    logic signed [SUM_W-1:0] msg_sum;
    result_t          push_item;
    logic             cfg_wr;

    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_WINDOW_SIZE) ? {27'd0, win_size_reg} : 32'd0;
    assign s_tready = (state_reg == ST_IDLE);
    assign take     = s_tvalid && s_tready;

    assign m_tvalid = (fifo_count_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign occ      = {1'b0, fifo_count_reg} + {2'b0, iss_valid_reg};
    assign can_issue = (occ - {2'b0, pop}) <= 3'd1;
    assign emit     = emit_req && can_issue;

    always_comb begin
        if (win_size_reg == 5'd0) begin
            eff_w = WIN_W'(1);
        end else if (32'(win_size_reg) > 32'(WIN_CAP)) begin
            eff_w = WIN_W'(WIN_CAP);
        end else begin
            eff_w = WIN_W'(win_size_reg);
        end
    end

    assign in_flight = next_reg - base_reg;
    assign ack_dist  = ack_a_reg - base_reg;
    assign ack_ok    = ((ack_s_reg + ack_a_reg) == ack_c_reg) && (ack_dist < in_flight);
    assign full      = (stored_reg - base_reg) >= DEPTH_32;
    assign room      = (in_flight < 32'(eff_w)) ? eff_w - in_flight[WIN_W-1:0] : '0;
    assign avail     = stored_reg - next_reg;
    assign cnt_fresh = (avail < 32'(room)) ? avail[WIN_W-1:0] : room;
    assign ofs       = ack_dist[IDX_W:0] + 1'b1;
    assign idx_sum   = {1'b0, base_idx_reg} + ofs;
    assign msg_sum   = SUM_W'(byte_sum8(w0_reg)) + SUM_W'(byte_sum8(w1_reg))
                     + SUM_W'(byte_sum8({32'd0, w2_reg}));

    always_comb begin
        state_next    = state_reg;
        win_size_next = cfg_wr ? pwdata[4:0] : win_size_reg;
        base_next     = base_reg;
        next_next     = next_reg;
        stored_next   = stored_reg;
        base_idx_next = base_idx_reg;
        next_idx_next = next_idx_reg;
        wr_idx_next   = wr_idx_reg;
        scan_seq_next = scan_seq_reg;
        scan_idx_next = scan_idx_reg;
        cnt_next      = cnt_reg;
        tcmd_next     = tcmd_reg;
        fresh_next    = fresh_reg;
        mem_we        = 1'b0;
        emit_req      = 1'b0;
        emit_pkt      = 1'b0;
        emit_ovf      = 1'b0;
        emit_last     = 1'b1;
        emit_seq      = scan_seq_reg;
        emit_tcmd     = TCMD_NONE;

        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (op_reg)
                    OP_MSG: begin
                        if (full) begin
                            emit_req = 1'b1;
                            emit_ovf = 1'b1;
                            if (can_issue) begin
                                state_next = ST_IDLE;
                            end
                        end else begin
                            mem_we      = 1'b1;
                            stored_next = stored_reg + 1'b1;
                            wr_idx_next = idx_inc(wr_idx_reg);
                            tcmd_next   = (in_flight == 32'd0) ? TCMD_START : TCMD_NONE;
                            state_next  = ST_PREP;
                        end
                    end
                    OP_ACK: begin
                        if (ack_ok) begin
                            base_next     = ack_a_reg + 1'b1;
                            base_idx_next = (idx_sum >= (IDX_W + 1)'(BUFFER_DEPTH))
                                ? IDX_W'(idx_sum - (IDX_W + 1)'(BUFFER_DEPTH))
                                : idx_sum[IDX_W-1:0];
                            state_next    = ST_PREP;
                        end else begin
                            emit_req = 1'b1;
                            if (can_issue) begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    OP_TIMEOUT: begin
                        if (in_flight == 32'd0) begin
                            emit_req  = 1'b1;
                            emit_tcmd = TCMD_STOP;
                            if (can_issue) begin
                                state_next = ST_IDLE;
                            end
                        end else begin
                            // resend everything from the window base
                            scan_seq_next = base_reg;
                            scan_idx_next = base_idx_reg;
                            cnt_next      = in_flight[WIN_W-1:0];
                            tcmd_next     = TCMD_START;
                            fresh_next    = 1'b0;
                            state_next    = ST_SEND;
                        end
                    end
                    default: begin
                        emit_req = 1'b1;
                        if (can_issue) begin
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_PREP: begin
                if (cnt_fresh == '0) begin
                    emit_req = 1'b1;
                    if (op_reg == OP_ACK) begin
                        emit_tcmd = (in_flight == 32'd0) ? TCMD_STOP : TCMD_START;
                    end
                    if (can_issue) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    scan_seq_next = next_reg;
                    scan_idx_next = next_idx_reg;
                    cnt_next      = cnt_fresh;
                    fresh_next    = 1'b1;
                    if (op_reg == OP_ACK) begin
                        tcmd_next = TCMD_START;
                    end
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                emit_req  = 1'b1;
                emit_pkt  = 1'b1;
                emit_last = (cnt_reg == WIN_W'(1));
                emit_tcmd = emit_last ? tcmd_reg : TCMD_NONE;
                if (can_issue) begin
                    scan_seq_next = scan_seq_reg + 1'b1;
                    scan_idx_next = idx_inc(scan_idx_reg);
                    cnt_next      = cnt_reg - 1'b1;
                    if (fresh_reg) begin
                        next_next     = scan_seq_reg + 1'b1;
                        next_idx_next = idx_inc(scan_idx_reg);
                    end
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result assembly from the issue stage and the memory read data
    always_comb begin
        push_item            = '0;
        push_item.has_packet = iss_pkt_reg;
        push_item.last       = iss_last_reg;
        push_item.overflow   = iss_ovf_reg;
        push_item.timer_cmd  = iss_tcmd_reg;
        if (iss_pkt_reg) begin
            push_item.seq   = iss_seq_reg;
            push_item.check = 32'(signed'(rd_data_reg[MEM_W-1:160]))
                            + {iss_seq_reg[30:0], 1'b0};
            push_item.word0 = rd_data_reg[63:0];
            push_item.word1 = rd_data_reg[127:64];
            push_item.word2 = rd_data_reg[159:128];
        end
    end

    always_comb begin
        fifo_count_next = fifo_count_reg + {1'b0, iss_valid_reg} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            win_size_reg    <= WINDOW_SIZE_RST;
            base_reg        <= '0;
            next_reg        <= '0;
            stored_reg      <= '0;
            base_idx_reg    <= '0;
            next_idx_reg    <= '0;
            wr_idx_reg      <= '0;
            scan_seq_reg    <= '0;
            scan_idx_reg    <= '0;
            cnt_reg         <= '0;
            tcmd_reg        <= TCMD_NONE;
            fresh_reg       <= 1'b0;
            iss_valid_reg   <= 1'b0;
            fifo_count_reg  <= '0;
            fifo_wr_ptr_reg <= 1'b0;
            fifo_rd_ptr_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            win_size_reg    <= win_size_next;
            base_reg        <= base_next;
            next_reg        <= next_next;
            stored_reg      <= stored_next;
            base_idx_reg    <= base_idx_next;
            next_idx_reg    <= next_idx_next;
            wr_idx_reg      <= wr_idx_next;
            scan_seq_reg    <= scan_seq_next;
            scan_idx_reg    <= scan_idx_next;
            cnt_reg         <= cnt_next;
            tcmd_reg        <= tcmd_next;
            fresh_reg       <= fresh_next;
            iss_valid_reg   <= emit;
            fifo_count_reg  <= fifo_count_next;
            if (iss_valid_reg) begin
                fifo_wr_ptr_reg <= ~fifo_wr_ptr_reg;
            end
            if (pop) begin
                fifo_rd_ptr_reg <= ~fifo_rd_ptr_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (take) begin
            op_reg    <= s_tuser;
            w0_reg    <= s_tdata[63:0];
            w1_reg    <= s_tdata[127:64];
            w2_reg    <= s_tdata[159:128];
            ack_s_reg <= s_tdata[191:160];
            ack_a_reg <= s_tdata[223:192];
            ack_c_reg <= s_tdata[255:224];
        end
        if (emit) begin
            iss_pkt_reg  <= emit_pkt;
            iss_ovf_reg  <= emit_ovf;
            iss_last_reg <= emit_last;
            iss_seq_reg  <= emit_seq;
            iss_tcmd_reg <= emit_tcmd;
        end
        if (iss_valid_reg) begin
            fifo_reg[fifo_wr_ptr_reg] <= push_item;
        end
    end

    // Payload ring: byte sum stored with the payload
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_idx_reg] <= {msg_sum, w2_reg, w1_reg, w0_reg};
        end
        if (emit && emit_pkt) begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

    result_t head;
    assign head    = fifo_reg[fifo_rd_ptr_reg];
    assign m_tdata = {5'd0, head.overflow, head.timer_cmd, head.word2, head.word1,
                      head.word0, head.check, head.seq};
    assign m_tuser = head.has_packet;
    assign m_tlast = head.last;

endmodule

>>> hdl/gbn_port_checker.sv
// Port-level checks on the result stream of the go-back-n sender core.
// Depends on gbn_pkg; bound to go_back_n_sender_core below.
module gbn_port_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [gbn_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);
    import gbn_pkg::*;

    // Hold a stalled transaction
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[TCMD_LSB-1:0] == '0)
        else $error("result without packet carries packet fields");

    a_overflow_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OVF_BIT] |-> m_tlast && !m_tuser
                                         && m_tdata[TCMD_LSB +: 2] == TCMD_NONE)
        else $error("overflow result malformed");

    a_tcmd_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser && m_tdata[TCMD_LSB +: 2] == TCMD_NONE)
        else $error("timer command or empty result before the last one");

    a_tcmd_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[TCMD_LSB +: 2] == TCMD_NONE
                     || m_tdata[TCMD_LSB +: 2] == TCMD_START
                     || m_tdata[TCMD_LSB +: 2] == TCMD_STOP)
        else $error("undefined timer command");

endmodule

bind go_back_n_sender_core gbn_port_checker u_gbn_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> verif/go_back_n_sender_core_tb.sv
// Self-checking testbench for go_back_n_sender_core: directed and random message,
// ack and timeout traffic, with packet results predicted by an in-bench tracker.
// Depends on gbn_pkg and the go_back_n_sender_core RTL.
`timescale 1ns / 1ps

module go_back_n_sender_core_tb;
    import gbn_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         RING_DEPTH  = BUFFER_DEPTH_DEF;

    typedef enum logic [1:0] {TR_FILL, TR_DRAIN, TR_MIX} traffic_e;
    typedef enum logic [2:0] {K_MSG, K_GOOD_ACK, K_BAD_ACK, K_TIMEOUT, K_UNUSED} item_kind_e;

    // Tracks the sender's window and ring, and holds the packets it must emit.
    class gbn_tx_tracker;
        logic [159:0] ring [RING_DEPTH];
        logic [31:0]  base;
        logic [31:0]  send_seq;
        logic [31:0]  stored;
        logic [4:0]   win_reg;
        result_t      due_results [$];
        int           failures;

        function new();
            base     = '0;
            send_seq = '0;
            stored   = '0;
            win_reg  = WINDOW_SIZE_RST;
            failures = 0;
        endfunction

        function void set_window(logic [4:0] v);
            win_reg = v;
        endfunction

        function result_t packet_of(logic [31:0] seq);
            result_t      r;
            logic [159:0] entry;
            logic [31:0]  ck;
            logic [7:0]   b;
            r     = '0;
            entry = ring[seq % RING_DEPTH];
            ck    = seq << 1;
            for (int i = 0; i < 20; i++) begin
                b  = entry[8*i +: 8];
                ck = ck + {{24{b[7]}}, b};
            end
            r.has_packet = 1'b1;
            r.seq        = seq;
            r.check      = ck;
            {r.word2, r.word1, r.word0} = entry;
            return r;
        endfunction

        // Send buffered messages while the window has room.
        function void release_fresh();
            logic [31:0] lim;
            lim = 32'(win_reg);
            if (lim < 1) lim = 1;
            if (lim > MAX_WINDOW_DEF) lim = MAX_WINDOW_DEF;
            if (lim > RING_DEPTH) lim = RING_DEPTH;
            while ((send_seq - base) < lim && send_seq != stored) begin
                due_results.push_back(packet_of(send_seq));
                send_seq = send_seq + 1;
            end
        endfunction

        function void take_input(logic [1:0] op, logic [IN_TDATA_W-1:0] d);
            result_t     r;
            int          start_cnt;
            logic [31:0] s, a, c, span;
            logic [1:0]  tcmd;
            bit          was_empty;
            start_cnt = due_results.size();
            tcmd      = TCMD_NONE;
            case (op)
                OP_MSG: begin
                    if ((stored - base) >= RING_DEPTH) begin
                        r          = '0;
                        r.overflow = 1'b1;
                        r.last     = 1'b1;
                        due_results.push_back(r);
                        return;
                    end
                    ring[stored % RING_DEPTH] = d[159:0];
                    stored    = stored + 1;
                    was_empty = (send_seq == base);
                    release_fresh();
                    if (due_results.size() > start_cnt && was_empty) tcmd = TCMD_START;
                end
                OP_ACK: begin
                    s = d[191:160];
                    a = d[223:192];
                    c = d[255:224];
                    if (s + a == c && (a - base) < (send_seq - base)) begin
                        base = a + 1;
                        release_fresh();
                        tcmd = (base == send_seq) ? TCMD_STOP : TCMD_START;
                    end
                end
                OP_TIMEOUT: begin
                    span = send_seq - base;
                    for (int unsigned i = 0; i < span; i++) begin
                        due_results.push_back(packet_of(base + i));
                    end
                    tcmd = (span == 0) ? TCMD_STOP : TCMD_START;
                end
                default: ;
            endcase
            if (due_results.size() == start_cnt) begin
                r = '0;
                due_results.push_back(r);
            end
            // Timer command and end marker ride on the final result only
            r           = due_results[due_results.size()-1];
            r.timer_cmd = tcmd;
            r.last      = 1'b1;
            due_results[due_results.size()-1] = r;
        endfunction

        function string show(result_t r);
            return $sformatf("pkt=%0b seq=%h chk=%h w=%h_%h_%h tcmd=%0d ovf=%0b last=%0b",
                             r.has_packet, r.seq, r.check, r.word2, r.word1, r.word0,
                             r.timer_cmd, r.overflow, r.last);
        endfunction

        function void complain(string what, result_t want, result_t got);
            failures++;
            if (failures <= 10) begin
                $display("%0t: %s", $time, what);
                $display("  expected %s", show(want));
                $display("  actual   %s", show(got));
            end
        endfunction

        function void match_result(logic [OUT_TDATA_W-1:0] t, logic user, logic tl);
            result_t got, want;
            got            = '0;
            got.seq        = t[31:0];
            got.check      = t[63:32];
            got.word0      = t[127:64];
            got.word1      = t[191:128];
            got.word2      = t[223:192];
            got.timer_cmd  = t[TCMD_LSB +: 2];
            got.overflow   = t[OVF_BIT];
            got.has_packet = user;
            got.last       = tl;
            if (due_results.size() == 0) begin
                complain("result with no transaction outstanding", '0, got);
                return;
            end
            want = due_results.pop_front();
            if (got.has_packet !== want.has_packet || got.seq !== want.seq ||
                got.check !== want.check || got.word0 !== want.word0 ||
                got.word1 !== want.word1 || got.word2 !== want.word2 ||
                got.timer_cmd !== want.timer_cmd || got.overflow !== want.overflow ||
                got.last !== want.last) begin
                complain("result mismatch", want, got);
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    gbn_tx_tracker tracker;
    int            src_gap_pct;
    int            sink_stall_pct;
    int            cycle_count;
    traffic_e      traffic;
    int            mix_left;
    int            drops;

    go_back_n_sender_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: check each transaction, then stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.match_result(m_tdata, m_tuser, m_tlast);
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [IN_TDATA_W-1:0] pack_in(input logic [63:0] w0, w1,
                                                      input logic [31:0] w2, s, a, c);
        return {c, a, s, w2, w1, w0};
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return {8{8'h80}};
            3:       return {8{8'h7f}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [IN_TDATA_W-1:0] d);
        if ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        tracker.take_input(op, d);
    endtask

    task automatic send_msg(input logic [63:0] w0, w1, input logic [31:0] w2);
        send_item(OP_MSG, pack_in(w0, w1, w2, $urandom, $urandom, $urandom));
    endtask

    task automatic send_ack(input logic [31:0] s, a, c);
        send_item(OP_ACK, pack_in(pick_word(), pick_word(), 32'(pick_word()), s, a, c));
    endtask

    task automatic send_bare(input logic [1:0] op);
        send_item(op, pack_in(pick_word(), pick_word(), 32'(pick_word()),
                              $urandom, $urandom, $urandom));
    endtask

    // Hold off until every expected result has been taken
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_window(input logic [4:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_WINDOW_SIZE, 2'b00};
        pwdata  <= {27'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.set_window(v);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Fill the ring to overflow, drain it with acks, then mix everything
    task automatic draw_item(output logic [1:0] op, output logic [IN_TDATA_W-1:0] d);
        logic [31:0] held, flight, s, a, c;
        int          roll, t_msg, t_good, t_bad, t_to;
        item_kind_e  kind;
        held   = tracker.stored - tracker.base;
        flight = tracker.send_seq - tracker.base;
        case (traffic)
            TR_FILL: if (drops >= 3) begin
                traffic = TR_DRAIN;
                drops   = 0;
            end
            TR_DRAIN: if (flight == 0) begin
                traffic  = TR_MIX;
                mix_left = 40;
            end
            default: if (mix_left == 0) traffic = TR_FILL; else mix_left--;
        endcase
        case (traffic)
            TR_FILL: begin
                t_msg = 88; t_good = 90; t_bad = 92; t_to = 100;
            end
            TR_DRAIN: begin
                t_msg = 10; t_good = 80; t_bad = 88; t_to = 100;
            end
            default: begin
                t_msg = 45; t_good = 72; t_bad = 84; t_to = 97;
            end
        endcase
        roll = $urandom_range(99);
        if (roll < t_msg) kind = K_MSG;
        else if (roll < t_good) kind = K_GOOD_ACK;
        else if (roll < t_bad) kind = K_BAD_ACK;
        else if (roll < t_to) kind = K_TIMEOUT;
        else kind = K_UNUSED;

        d = pack_in(pick_word(), pick_word(), 32'(pick_word()), $urandom, $urandom, $urandom);
        case (kind)
            K_MSG: begin
                op = OP_MSG;
                if (traffic == TR_FILL && held >= RING_DEPTH) drops++;
            end
            K_GOOD_ACK, K_BAD_ACK: begin
                op = OP_ACK;
                s  = $urandom;
                if (kind == K_GOOD_ACK && flight != 0) begin
                    a = tracker.base + $urandom_range(flight - 1);
                    c = s + a;
                end else begin
                    case ($urandom_range(3))
                        0: begin
                            a = tracker.base + $urandom_range(flight);
                            c = s + a + (32'd1 << $urandom_range(31));
                        end
                        1: begin
                            a = tracker.base - 1 - $urandom_range(999);
                            c = s + a;
                        end
                        2: begin
                            a = tracker.send_seq + $urandom_range(999);
                            c = s + a;
                        end
                        default: begin
                            a = $urandom;
                            c = $urandom;
                        end
                    endcase
                end
                d[255:160] = {c, a, s};
            end
            K_TIMEOUT: op = OP_TIMEOUT;
            default:   op = OP_UNUSED;
        endcase
    endtask

    initial begin
        logic [1:0]            op;
        logic [IN_TDATA_W-1:0] d;
        logic [4:0]            win_plan [6];
        int                    count;

        tracker        = new();
        cycle_count    = 0;
        src_gap_pct    = 16;
        sink_stall_pct = 75;
        traffic        = TR_MIX;
        mix_left       = 40;
        drops          = 0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        win_plan       = '{5'd1, 5'd16, 5'd15, 5'd16, 5'd1, 5'(2 + $urandom_range(13))};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-window cases, byte extremes, bad and stale acks, wrap of the
        // checksum, retransmission, buffered release and window emptied by an ack
        send_bare(OP_TIMEOUT);
        send_ack(32'd5, 32'd0, 32'd5);
        send_bare(OP_UNUSED);
        send_msg('0, '0, '0);
        send_msg('1, '1, '1);
        send_msg({8{8'h80}}, {8{8'h80}}, {4{8'h80}});
        send_msg({8{8'h7f}}, {8{8'h7f}}, {4{8'h7f}});
        send_ack(32'd0, 32'd0, 32'h8000_0000);
        send_ack(32'd0, 32'd1, 32'h7fff_ffff);
        send_ack(32'hffff_ffff, tracker.send_seq, 32'hffff_ffff + tracker.send_seq);
        send_ack(32'hffff_ffff, 32'd1, 32'd0);
        send_bare(OP_TIMEOUT);
        repeat (10) send_msg(pick_word(), pick_word(), 32'(pick_word()));
        send_ack(32'd7, tracker.send_seq - 1, 32'd6 + tracker.send_seq);
        send_ack(32'd0, tracker.send_seq - 1, tracker.send_seq - 1);
        send_bare(OP_TIMEOUT);

        for (int seg = 0; seg < 6; seg++) begin
            settle();
            case (seg / 2)
                0: begin
                    src_gap_pct    = 16;
                    sink_stall_pct = 75;
                end
                1: begin
                    src_gap_pct    = 75;
                    sink_stall_pct = 16;
                end
                default: begin
                    src_gap_pct    = 0;
                    sink_stall_pct = 0;
                end
            endcase
            write_window(win_plan[seg]);
            count = 0;
            while (count < 67) begin
                draw_item(op, d);
                send_item(op, d);
                if (op != OP_UNUSED) count++;
            end
        end

        settle();
        repeat (40) @(posedge aclk);
        if (tracker.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/gbn_pkg.sv
hdl/go_back_n_sender_core.sv
hdl/gbn_port_checker.sv
verif/go_back_n_sender_core_tb.sv
